FILE: sv/depth_tested_pixel_blender_defines.svh
// ----------------------------------------------------------------------------
// depth tested pixel blender assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef DEPTH_TESTED_PIXEL_BLENDER_DEFINES_SVH
`define DEPTH_TESTED_PIXEL_BLENDER_DEFINES_SVH

// same-cycle implication, skipped while reset is low
`define DTPB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, skipped while reset is low
`define DTPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: sv/dtpb_pkg.sv
// ----------------------------------------------------------------------------
// dtpb_pkg
// types, codes and helpers shared by the pixel blender modules
// ----------------------------------------------------------------------------
package dtpb_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int DEPTH_BITS_DEF = 24;

    // coordinate width: holds any sum of two 12-bit signed values and 4096
    localparam int CW       = 14;
    localparam int ADDR_MAX = 24;
    localparam int DEP_MAX  = 32;

    localparam logic [2:0] REQ_WR_OPAQUE = 3'd0;
    localparam logic [2:0] REQ_WR_BLEND  = 3'd1;
    localparam logic [2:0] REQ_RD_COLOR  = 3'd2;
    localparam logic [2:0] REQ_RD_DEPTH  = 3'd3;
    localparam logic [2:0] REQ_CLR_COLOR = 3'd4;
    localparam logic [2:0] REQ_CLR_DEPTH = 3'd5;

    localparam logic [2:0] CFG_SURF_W  = 3'd0;
    localparam logic [2:0] CFG_SURF_H  = 3'd1;
    localparam logic [2:0] CFG_CLR_R   = 3'd2;
    localparam logic [2:0] CFG_CLR_G   = 3'd3;
    localparam logic [2:0] CFG_CLR_B   = 3'd4;
    localparam logic [2:0] CFG_CLR_A   = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;

    typedef enum logic [2:0] {
        K_NOP,
        K_WR_OPAQUE,
        K_WR_BLEND,
        K_RD_COLOR,
        K_RD_DEPTH,
        K_CLR_COLOR,
        K_CLR_DEPTH
    } t_kind;

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_EVAL,
        B_BLEND,
        B_CLR
    } t_bstate;

    typedef struct packed {
        t_kind                 kind;
        logic                  on_surf;
        logic                  empty;
        logic [ADDR_MAX-1:0]   addr;
        logic [31:0]           color;
        logic [DEP_MAX-1:0]    depth;
        logic [CW-1:0]         x0;
        logic [CW-1:0]         x1;
        logic [CW-1:0]         y0;
        logic [CW-1:0]         y1;
    } t_cmd;

    typedef struct packed {
        logic init;
        logic pop;
    } t_back_stat;

    // exact floor(s / 255) for s up to 255 * 255
    function automatic logic [7:0] div255(input logic [16:0] s);
        logic [16:0] t;
        t = s + 17'd1 + {8'd0, s[16:8]};
        return t[15:8];
    endfunction

endpackage

FILE: sv/depth_tested_pixel_blender.sv
// ----------------------------------------------------------------------------
// depth_tested_pixel_blender
// z-buffered raster output unit with opaque and alpha-blended pixel writes
// ----------------------------------------------------------------------------
// After reset the block clears all MAX_WIDTH*MAX_HEIGHT pixels of both stores
// (65536 by default), one pixel per cycle, and takes no request until that is
// done; configuration writes are taken throughout. Requests are queued two
// deep and executed one at a time in the back part. An outside pixel, an
// unused type or an empty clear is answered from the idle state; a read, an
// opaque write or a depth reject ends in the evaluate state; a blended write
// goes on to the blend state (store read, multiply, divide and write back);
// a region clear writes its clipped rectangle one pixel per cycle through the
// store write port. One result per request leaves in order through a registered output.
// ----------------------------------------------------------------------------
`include "depth_tested_pixel_blender_defines.svh"

module depth_tested_pixel_blender
    import dtpb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [8:0]   i_cfg_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // offset_x, offset_y, pixel_x, pixel_y, src_red, src_green, src_blue,
    // src_alpha, src_depth, region_w, region_h, zero fill
    input  logic [127:0] i_s_axis_tdata,
    // req_type
    input  logic [2:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // out_red, out_green, out_blue, out_alpha, out_depth
    output logic [55:0]  o_m_axis_tdata,
    // status
    output logic [1:0]   o_m_axis_tuser
);

    logic [8:0] r_surf_w, r_surf_h;
    logic [7:0] r_clr_r, r_clr_g, r_clr_b, r_clr_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surf_w <= 9'd256;
            r_surf_h <= 9'd256;
            r_clr_r  <= '0;
            r_clr_g  <= '0;
            r_clr_b  <= '0;
            r_clr_a  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SURF_W: r_surf_w <= i_cfg_data;
                CFG_SURF_H: r_surf_h <= i_cfg_data;
                CFG_CLR_R:  r_clr_r  <= i_cfg_data[7:0];
                CFG_CLR_G:  r_clr_g  <= i_cfg_data[7:0];
                CFG_CLR_B:  r_clr_b  <= i_cfg_data[7:0];
                CFG_CLR_A:  r_clr_a  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    t_cmd       cmd, head;
    logic       push, q_empty, q_full;
    t_back_stat bstat;

    dtpb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .i_tuser  (i_s_axis_tuser),
        .i_stall  (q_full || bstat.init),
        .i_surf_w (r_surf_w),
        .i_surf_h (r_surf_h),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    dtpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (bstat.pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    dtpb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_empty       (q_empty),
        .i_clear_color ({r_clr_a, r_clr_b, r_clr_g, r_clr_r}),
        .o_stat        (bstat),
        .o_tvalid      (o_m_axis_tvalid),
        .i_tready      (i_m_axis_tready),
        .o_tdata       (o_m_axis_tdata),
        .o_tuser       (o_m_axis_tuser)
    );

    // no request is taken while the stores are being cleared
    `DTPB_ASSERT_SAME(a_no_accept_in_init, i_clk, i_rst_n, bstat.init, !o_s_axis_tready)
    // the back part only pops a queued item
    `DTPB_ASSERT_SAME(a_pop_not_empty, i_clk, i_rst_n, bstat.pop, !q_empty)
    // a pop never overruns a result still waiting downstream
    `DTPB_ASSERT_SAME(a_pop_out_free, i_clk, i_rst_n, bstat.pop,
        !o_m_axis_tvalid || i_m_axis_tready)
    // an item pushed into a full queue would be lost
    `DTPB_ASSERT_SAME(a_push_not_full, i_clk, i_rst_n, push, !q_full)

endmodule

FILE: sv/dtpb_front.sv
// ----------------------------------------------------------------------------
// dtpb_front
// accepts requests, places them on the surface and classifies them
// ----------------------------------------------------------------------------
module dtpb_front
    import dtpb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic         i_tvalid,
    output logic         o_tready,
    input  logic [127:0] i_tdata,
    input  logic [2:0]   i_tuser,
    input  logic         i_stall,
    input  logic [8:0]   i_surf_w,
    input  logic [8:0]   i_surf_h,
    output logic         o_push,
    output t_cmd         o_cmd
);

    logic signed [CW-1:0] ox, oy, px, py, x0, y0, x1r, y1r, x1, y1, w, h;
    logic                 on_surf;
    t_kind                kind;

    assign ox = CW'(signed'(i_tdata[11:0]));
    assign oy = CW'(signed'(i_tdata[23:12]));
    assign px = ox + CW'(signed'(i_tdata[35:24]));
    assign py = oy + CW'(signed'(i_tdata[47:36]));

    assign w = ({5'd0, i_surf_w} > CW'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : {5'd0, i_surf_w};
    assign h = ({5'd0, i_surf_h} > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : {5'd0, i_surf_h};

    assign on_surf = (px >= 0) && (py >= 0) && (px < w) && (py < h);

    // clipped clear rectangle
    assign x0  = (ox < 0) ? '0 : ox;
    assign y0  = (oy < 0) ? '0 : oy;
    assign x1r = ox + signed'({5'd0, i_tdata[112:104]});
    assign y1r = oy + signed'({5'd0, i_tdata[121:113]});
    assign x1  = (x1r > w) ? w : x1r;
    assign y1  = (y1r > h) ? h : y1r;

    always_comb begin
        unique case (i_tuser)
            REQ_WR_OPAQUE: kind = K_WR_OPAQUE;
            REQ_WR_BLEND:  kind = K_WR_BLEND;
            REQ_RD_COLOR:  kind = K_RD_COLOR;
            REQ_RD_DEPTH:  kind = K_RD_DEPTH;
            REQ_CLR_COLOR: kind = K_CLR_COLOR;
            REQ_CLR_DEPTH: kind = K_CLR_DEPTH;
            default:       kind = K_NOP;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.kind    = kind;
        o_cmd.on_surf = on_surf;
        o_cmd.empty   = (x0 >= x1) || (y0 >= y1);
        o_cmd.addr    = ADDR_MAX'(32'(unsigned'(py)) * 32'(MAX_WIDTH) + 32'(unsigned'(px)));
        o_cmd.color   = i_tdata[79:48];
        o_cmd.depth   = DEP_MAX'(i_tdata[103:80]);
        o_cmd.x0      = x0;
        o_cmd.x1      = x1;
        o_cmd.y0      = y0;
        o_cmd.y1      = y1;
    end

    assign o_tready = !i_stall;
    assign o_push   = i_tvalid && !i_stall;

endmodule

FILE: sv/dtpb_queue.sv
// ----------------------------------------------------------------------------
// dtpb_queue
// two-entry command queue between the front and back parts
// ----------------------------------------------------------------------------
module dtpb_queue
    import dtpb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    t_cmd       r_slot [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr] <= i_cmd;
    end

    assign o_head  = r_slot[r_rd];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

endmodule

FILE: sv/dtpb_back.sv
// ----------------------------------------------------------------------------
// dtpb_back
// executes commands against the color and depth stores, holds the result
// ----------------------------------------------------------------------------
module dtpb_back
    import dtpb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_head,
    input  logic        i_empty,
    input  logic [31:0] i_clear_color,
    output t_back_stat  o_stat,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [55:0] o_tdata,
    output logic [1:0]  o_tuser
);

    localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
    localparam logic [DEPTH_BITS-1:0] FAR = {DEPTH_BITS{1'b1}};

    logic [31:0]           r_cmem [NPIX];
    logic [DEPTH_BITS-1:0] r_dmem [NPIX];

    t_bstate               r_state, n_state;
    t_cmd                  r_cmd;
    logic [31:0]           r_cdata;
    logic [DEPTH_BITS-1:0] r_ddata;
    logic [15:0]           r_prod_c [4];
    logic [15:0]           r_prod_d [4];
    logic [CW-1:0]         r_x, r_y;
    logic [AW-1:0]         r_sweep;
    logic                  r_ovalid;
    logic [1:0]            r_ost;
    logic [31:0]           r_ocolor;
    logic [23:0]           r_odepth;

    logic                  can_go, pop, prod_load, res_load, clr_last, x_last;
    logic                  c_we, d_we;
    logic [AW-1:0]         raddr, c_waddr, d_waddr, clr_addr;
    logic [31:0]           c_wdata, res_color, blend_color;
    logic [DEPTH_BITS-1:0] d_wdata, sd;
    logic [1:0]            res_st;
    logic [23:0]           res_depth;

    assign can_go   = !i_empty && (!r_ovalid || i_tready);
    assign sd       = DEPTH_BITS'(r_cmd.depth);
    assign clr_addr = AW'(32'(r_y) * 32'(MAX_WIDTH) + 32'(r_x));
    assign x_last   = (r_x + CW'(1)) == r_cmd.x1;
    assign clr_last = x_last && ((r_y + CW'(1)) == r_cmd.y1);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            blend_color[8*i +: 8] = div255({1'b0, r_prod_c[i]} + {1'b0, r_prod_d[i]});
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_INIT: begin
                if (r_sweep == AW'(NPIX - 1)) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (can_go) begin
                    unique case (i_head.kind)
                        K_WR_OPAQUE, K_WR_BLEND, K_RD_COLOR, K_RD_DEPTH: begin
                            if (i_head.on_surf) n_state = B_EVAL;
                        end
                        K_CLR_COLOR, K_CLR_DEPTH: begin
                            if (!i_head.empty) n_state = B_CLR;
                        end
                        default: n_state = B_IDLE;
                    endcase
                end
            end
            B_EVAL: begin
                if (r_cmd.kind == K_WR_BLEND && sd <= r_ddata) n_state = B_BLEND;
                else                                            n_state = B_IDLE;
            end
            B_BLEND: n_state = B_IDLE;
            B_CLR: begin
                if (clr_last) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        pop       = 1'b0;
        prod_load = 1'b0;
        res_load  = 1'b0;
        res_st    = ST_OK;
        res_color = '0;
        res_depth = '0;
        c_we      = 1'b0;
        d_we      = 1'b0;
        c_waddr   = AW'(r_cmd.addr);
        d_waddr   = AW'(r_cmd.addr);
        c_wdata   = r_cmd.color;
        d_wdata   = sd;
        raddr     = AW'(i_head.addr);
        unique case (r_state)
            B_INIT: begin
                c_we    = 1'b1;
                d_we    = 1'b1;
                c_waddr = r_sweep;
                d_waddr = r_sweep;
                c_wdata = '0;
                d_wdata = FAR;
            end
            B_IDLE: begin
                pop = can_go;
                unique case (i_head.kind)
                    K_WR_OPAQUE, K_WR_BLEND, K_RD_COLOR: begin
                        res_load = can_go && !i_head.on_surf;
                        res_st   = ST_OUTSIDE;
                    end
                    K_RD_DEPTH: begin
                        res_load  = can_go && !i_head.on_surf;
                        res_st    = ST_OUTSIDE;
                        res_depth = 24'(FAR);
                    end
                    K_CLR_COLOR, K_CLR_DEPTH: res_load = can_go && i_head.empty;
                    default:                  res_load = can_go;
                endcase
            end
            B_EVAL: begin
                unique case (r_cmd.kind)
                    K_RD_COLOR: begin
                        res_load  = 1'b1;
                        res_color = r_cdata;
                    end
                    K_RD_DEPTH: begin
                        res_load  = 1'b1;
                        res_depth = 24'(r_ddata);
                    end
                    default: begin
                        // depth test: pass when not farther than stored
                        if (sd > r_ddata) begin
                            res_load = 1'b1;
                            res_st   = ST_REJECT;
                        end else begin
                            d_we = 1'b1;
                            if (r_cmd.kind == K_WR_OPAQUE) begin
                                c_we     = 1'b1;
                                res_load = 1'b1;
                            end else begin
                                prod_load = 1'b1;
                            end
                        end
                    end
                endcase
            end
            B_BLEND: begin
                c_we     = 1'b1;
                c_wdata  = blend_color;
                res_load = 1'b1;
            end
            B_CLR: begin
                c_waddr  = clr_addr;
                d_waddr  = clr_addr;
                c_wdata  = i_clear_color;
                d_wdata  = FAR;
                c_we     = (r_cmd.kind == K_CLR_COLOR);
                d_we     = (r_cmd.kind == K_CLR_DEPTH);
                res_load = clr_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_we) r_cmem[c_waddr] <= c_wdata;
        r_cdata <= r_cmem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (d_we) r_dmem[d_waddr] <= d_wdata;
        r_ddata <= r_dmem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_INIT;
            r_sweep  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_INIT) r_sweep <= r_sweep + AW'(1);
            if (res_load)          r_ovalid <= 1'b1;
            else if (i_tready)     r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_head;
            r_x   <= i_head.x0;
            r_y   <= i_head.y0;
        end else if (r_state == B_CLR) begin
            if (x_last) begin
                r_x <= r_cmd.x0;
                r_y <= r_y + CW'(1);
            end else begin
                r_x <= r_x + CW'(1);
            end
        end
        if (prod_load) begin
            for (int i = 0; i < 4; i++) begin
                r_prod_c[i] <= ((i == 3) ? 8'hFF : r_cmd.color[8*i +: 8]) * r_cmd.color[31:24];
                r_prod_d[i] <= r_cdata[8*i +: 8] * (8'hFF - r_cmd.color[31:24]);
            end
        end
        if (res_load) begin
            r_ost    <= res_st;
            r_ocolor <= res_color;
            r_odepth <= res_depth;
        end
    end

    assign o_stat.init = (r_state == B_INIT);
    assign o_stat.pop  = pop;
    assign o_tvalid    = r_ovalid;
    assign o_tdata     = {r_odepth, r_ocolor};
    assign o_tuser     = r_ost;

endmodule
